// File: rtl/mpfe_pkg.sv
// ----------------------------------------------------------------------------
// mpfe_pkg
// Shared geometry constants, item kinds and the control/status words that
// pass between the controller and the datapath of the frame store engine.
// ----------------------------------------------------------------------------
package mpfe_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int GLYPH_COLUMNS  = 5;
  localparam int GLYPH_ROWS     = 7;

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam int GLYPH_W = 35;
  localparam int POS_W   = $clog2(GLYPH_W);
  localparam int COL_W   = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_GLYPH = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;        // capture the accepted word
    logic issue;       // run one column/page pass of a draw
    logic clr_en;      // write zero at the sweep address
    logic rd_issue;    // start a store read
    logic rd_capture;  // move read data into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic last_pass;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/mpfe_ram.sv
// ----------------------------------------------------------------------------
// mpfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mpfe_ctrl.sv
// ----------------------------------------------------------------------------
// mpfe_ctrl
// Sequencer for the frame store engine: accepts one word at a time and
// steps the datapath through draw passes, clear sweeps and reads.
// ----------------------------------------------------------------------------
module mpfe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           kind_i,
  output logic                 in_stall_o,
  output mpfe_pkg::dp_cmd_t    cmd_o,
  input  mpfe_pkg::dp_status_t status_i
);
  import mpfe_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DRAW  = 5'b00100,
    ST_READ  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (kind_e'(kind_i))
            KIND_PIXEL: state_d = ST_DRAW;
            KIND_GLYPH: state_d = ST_DRAW;
            KIND_CLEAR: state_d = ST_CLEAR;
            KIND_READ:  state_d = ST_READ;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_pass) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output word slot frees up
        if (status_i.out_free) begin
          cmd_o.rd_capture = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/mpfe_datapath.sv
// ----------------------------------------------------------------------------
// mpfe_datapath
// Word registers, pass address/mask generation, two-stage read-modify-write
// into the frame store RAM, clear sweep counter and output word register.
// ----------------------------------------------------------------------------
module mpfe_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpfe_pkg::dp_cmd_t             cmd_i,
  output mpfe_pkg::dp_status_t          status_o,
  input  logic [1:0]                    kind_i,
  input  logic [7:0]                    x_i,
  input  logic [7:0]                    y_i,
  input  logic                          color_i,
  input  logic [mpfe_pkg::GLYPH_W-1:0]  glyph_bits_i,
  input  logic [9:0]                    read_index_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [7:0]                    read_data_o
);
  import mpfe_pkg::*;

  // captured word
  logic [1:0]         kind_q;
  logic [7:0]         x_q;
  logic [7:0]         y_q;
  logic               color_q;
  logic [GLYPH_W-1:0] glyph_q;
  logic [9:0]         ridx_q;

  // pass counter: column, then upper/lower page of that column
  logic [COL_W-1:0]   col_q;
  logic               half_q;
  logic               pixel;

  // stage A: address and mask of the current pass
  logic [7:0]         px_a;
  logic [4:0]         page_a;
  logic               col_ok;
  logic               page_ok;
  logic [3:0]         nrows;
  logic [7:0]         mask_a;
  logic [7:0]         data_a;
  logic [ADDR_W-1:0]  addr_a;
  logic               wr_ok_a;
  logic [7:0]         row;
  logic [7:0]         dr;
  logic [POS_W-1:0]   pos;
  logic               on;

  // stage B: merge and write back
  logic               b_valid_q;
  logic [ADDR_W-1:0]  b_addr_q;
  logic [7:0]         b_mask_q;
  logic [7:0]         b_data_q;

  logic [ADDR_W-1:0]  clr_cnt_q;
  logic               rd_oob_q;
  logic               out_valid_q;
  logic [7:0]         read_data_q;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      x_q     <= x_i;
      y_q     <= y_i;
      color_q <= color_i;
      glyph_q <= glyph_bits_i;
      ridx_q  <= read_index_i;
    end
  end

  assign pixel = (kind_e'(kind_q) == KIND_PIXEL);

  always_comb begin
    px_a    = x_q + 8'(col_q);
    page_a  = y_q[7:3] + 5'(half_q);
    col_ok  = {1'b0, px_a} < 9'(DISPLAY_WIDTH);
    page_ok = {1'b0, page_a} < 6'(PAGE_COUNT);
    nrows   = pixel ? 4'd1 : 4'(GLYPH_ROWS);
    row     = '0;
    dr      = '0;
    pos     = '0;
    on      = 1'b0;
    for (int b = 0; b < 8; b++) begin
      row       = {page_a, 3'(b)};
      dr        = row - y_q;
      mask_a[b] = ({1'b0, dr} < {5'b0, nrows}) && ({1'b0, row} < 9'(DISPLAY_HEIGHT));
      pos       = POS_W'(int'(col_q) * GLYPH_ROWS + int'(dr[2:0]));
      on        = pixel || ((int'(pos) < GLYPH_W) && glyph_q[pos]);
      data_a[b] = on ? color_q : ~color_q;
    end
    addr_a  = ADDR_W'(int'(px_a) + int'(page_a) * DISPLAY_WIDTH);
    wr_ok_a = col_ok && page_ok && (|mask_a);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      half_q    <= 1'b0;
      b_valid_q <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        col_q  <= '0;
        half_q <= 1'b0;
      end else if (cmd_i.issue) begin
        half_q <= ~half_q;
        if (half_q) begin
          col_q <= col_q + COL_W'(1);
        end
      end
      b_valid_q <= cmd_i.issue && wr_ok_a;
      if (cmd_i.clr_en) begin
        clr_cnt_q <= status_o.clr_last ? '0 : clr_cnt_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      b_addr_q <= addr_a;
      b_mask_q <= mask_a;
      b_data_q <= data_a;
    end
    if (cmd_i.rd_issue) begin
      rd_oob_q <= !(int'(ridx_q) < STORE_BYTES);
    end
  end

  // passes of one word never share a byte, so the write of one pass and the
  // read of the next cannot collide
  assign ram_we    = cmd_i.clr_en || b_valid_q;
  assign ram_waddr = cmd_i.clr_en ? clr_cnt_q : b_addr_q;
  assign ram_wdata = cmd_i.clr_en ? 8'h00 : ((ram_rdata & ~b_mask_q) | (b_data_q & b_mask_q));
  assign ram_re    = cmd_i.issue || cmd_i.rd_issue;
  assign ram_raddr = cmd_i.rd_issue ? ADDR_W'(int'(ridx_q)) : addr_a;

  mpfe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_capture) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_capture) begin
      read_data_q <= rd_oob_q ? 8'h00 : ram_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  assign status_o.last_pass = half_q && (pixel || (col_q == COL_W'(GLYPH_COLUMNS - 1)));
  assign status_o.clr_last  = (clr_cnt_q == ADDR_W'(STORE_BYTES - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

// File: rtl/mono_page_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine
// Page-ordered monochrome frame store with pixel, glyph, clear and read words.
// Each store byte holds eight vertical pixels at index x + (y/8) * width. The
// block takes one word at a time and raises in_stall_o until it is done; all
// store traffic goes through one RAM read port and one write port, with each
// draw done as read-modify-write passes of one column over one page. A pixel
// draw runs one column over two pages, a glyph draw GLYPH_COLUMNS columns over
// two pages each, and a read issues a store read and then waits for the
// output word slot to free. A clear writes zero to all STORE_BYTES (1024)
// bytes, one byte per cycle; after reset a clearing pass over the whole store
// runs with in_stall_o high. Read data sits in an output register, so further
// words are accepted while a read result waits to be taken.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [7:0]                    x_i,
  input  logic [7:0]                    y_i,
  input  logic                          color_i,
  input  logic [mpfe_pkg::GLYPH_W-1:0]  glyph_bits_i,
  input  logic [9:0]                    read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    read_data_o
);
  import mpfe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mpfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  mpfe_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .kind_i       (kind_i),
    .x_i          (x_i),
    .y_i          (y_i),
    .color_i      (color_i),
    .glyph_bits_i (glyph_bits_i),
    .read_index_i (read_index_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .read_data_o  (read_data_o)
  );

endmodule

// File: rtl/mpfe_checker.sv
// ----------------------------------------------------------------------------
// mpfe_checker
// Port-level checks of the frame store engine, bound to the top level.
// ----------------------------------------------------------------------------
module mpfe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [1:0]                    kind_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [7:0]                    read_data_o
);
  import mpfe_pkg::*;

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("result word dropped or changed under stall");

  // one word at a time: every accepted word closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // read into an empty output slot shows its result after passing through the read and response states
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (kind_i == KIND_READ) && !out_valid_o |-> ##3 out_valid_o)
    else $error("read result late or missing");

  // results only come out of a read in progress
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word appeared with no read in progress");

endmodule

bind mono_page_framebuffer_engine mpfe_checker u_checker (.*);

// File: test/tb_mono_page_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// tb_mono_page_framebuffer_engine
// Drives pixel, glyph, clear and read words into the frame store engine and
// checks every read byte against a behavioral copy of the page-ordered store or a byte
// from the directed table, which covers extremes, clipping, wrap and clear. A random
// phase follows with bursty idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_mono_page_framebuffer_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import mpfe_pkg::*;

  localparam int STALL_LIMIT  = 6000;  // covers the full-store clear sweeps plus hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 600;
  localparam int CALM_WORDS   = 100;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    kind_e              kind;
    logic [7:0]         x;
    logic [7:0]         y;
    logic               color;
    logic [GLYPH_W-1:0] glyph;
    logic [9:0]         ridx;
  } word_t;

  typedef struct {
    word_t      w;
    bit         typed;
    logic [7:0] data;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         kind_i;
  logic [7:0]         x_i;
  logic [7:0]         y_i;
  logic               color_i;
  logic [GLYPH_W-1:0] glyph_bits_i;
  logic [9:0]         read_index_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         read_data_o;

  logic [7:0] frame_model [STORE_BYTES];
  logic [7:0] pending_reads [$];
  row_t       directed_rows [$];
  int         recent_index;
  int         errors;
  int         reads_checked;
  int         words_sent;
  int         clears_sent;
  int         idle_count;
  bit         calm;
  bit         hold_done;
  logic [7:0] got_byte;

  mono_page_framebuffer_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .x_i          (x_i),
    .y_i          (y_i),
    .color_i      (color_i),
    .glyph_bits_i (glyph_bits_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void paint_pixel(int px, int py, bit lit);
    int idx;
    if (px >= DISPLAY_WIDTH || py >= DISPLAY_HEIGHT) return;
    idx = px + (py / 8) * DISPLAY_WIDTH;
    frame_model[idx][py % 8] = lit;
    recent_index = idx;
  endfunction

  // updates the store copy; the return value only matters for a read
  function automatic logic [7:0] apply_word(word_t w);
    int pos;
    case (w.kind)
      KIND_PIXEL: paint_pixel(w.x, w.y, w.color);
      KIND_GLYPH: begin
        for (int c = 0; c < GLYPH_COLUMNS; c++) begin
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            pos = c * GLYPH_ROWS + r;
            paint_pixel((int'(w.x) + c) & 8'hFF, (int'(w.y) + r) & 8'hFF,
                        w.glyph[pos] ? w.color : !w.color);
          end
        end
      end
      KIND_CLEAR: begin
        foreach (frame_model[i]) frame_model[i] = 8'h00;
      end
      KIND_READ: return (w.ridx < STORE_BYTES) ? frame_model[w.ridx] : 8'h00;
      default: ;
    endcase
    return 8'h00;
  endfunction

  function automatic word_t random_word();
    word_t       w;
    int          pick;
    logic [63:0] bits;
    pick = $urandom_range(0, 99);
    if (pick < 2) w.kind = KIND_CLEAR;
    else if (pick < 32) w.kind = KIND_PIXEL;
    else if (pick < 58) w.kind = KIND_GLYPH;
    else w.kind = KIND_READ;
    if ($urandom_range(0, 4) == 0) begin
      w.x = 8'($urandom_range(0, 255));
      w.y = 8'($urandom_range(0, 255));
    end else begin
      w.x = 8'($urandom_range(0, DISPLAY_WIDTH - 1));
      w.y = 8'($urandom_range(0, DISPLAY_HEIGHT - 1));
    end
    w.color = 1'($urandom_range(0, 1));
    bits = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w.glyph = '0;
      1: w.glyph = '1;
      default: w.glyph = bits[GLYPH_W-1:0];
    endcase
    // half the reads look at the byte last drawn so the checks see real data
    if ($urandom_range(0, 1) == 1) w.ridx = 10'(recent_index);
    else w.ridx = 10'($urandom_range(0, 1023));
    return w;
  endfunction

  task automatic add_row(kind_e kind, int x, int y, bit color, logic [GLYPH_W-1:0] glyph,
                         int ridx, bit typed, logic [7:0] data);
    row_t row;
    row.w.kind  = kind;
    row.w.x     = 8'(x);
    row.w.y     = 8'(y);
    row.w.color = color;
    row.w.glyph = glyph;
    row.w.ridx  = 10'(ridx);
    row.typed   = typed;
    row.data    = data;
    directed_rows.push_back(row);
  endtask

  // offer one word and hold it until taken; valid is left high
  task automatic drive_word(word_t w, bit typed, logic [7:0] data);
    logic [7:0] predicted;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    kind_i       <= w.kind;
    x_i          <= w.x;
    y_i          <= w.y;
    color_i      <= w.color;
    glyph_bits_i <= w.glyph;
    read_index_i <= w.ridx;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_word(w);
    if (w.kind == KIND_READ) pending_reads.push_back(typed ? data : predicted);
    if (w.kind == KIND_CLEAR) clears_sent++;
    words_sent++;
  endtask

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic note_error(string what, logic [7:0] want, logic [7:0] got);
    if (errors < 10)
      $display("%0t mismatch: %s expected %02h got %02h", $realtime, what, want, got);
    errors++;
  endtask

  // output side: random stall bursts, one long hold once reads are flowing
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && reads_checked >= 20) begin
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reads.size() == 0) begin
        note_error("unexpected read word", 8'h00, read_data_o);
      end else begin
        got_byte = pending_reads.pop_front();
        if (read_data_o !== got_byte) note_error("read_data", got_byte, read_data_o);
        reads_checked++;
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_count = 0;
      else idle_count++;
      if (idle_count >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("[mono_page_framebuffer_engine] ERROR");
        $finish;
      end
    end
  end

  initial begin
    word_t w;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_PIXEL;
    x_i          = '0;
    y_i          = '0;
    color_i      = 1'b0;
    glyph_bits_i = '0;
    read_index_i = '0;
    foreach (frame_model[i]) frame_model[i] = 8'h00;

    add_row(KIND_READ,    0,   0, 0, '0,    0,            1, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    1023,         1, 8'h00);
    add_row(KIND_PIXEL,   0,   0, 1, '0,    0,            0, 8'h00);
    add_row(KIND_PIXEL,   127, 63, 1, '0,   0,            0, 8'h00);
    add_row(KIND_PIXEL,   128, 0, 1, '1,    0,            0, 8'h00);  // off the right edge
    add_row(KIND_PIXEL,   0,   64, 1, '0,   0,            0, 8'h00);  // below the bottom
    add_row(KIND_PIXEL,   255, 255, 1, '1,  1023,         0, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    0,            1, 8'h01);
    add_row(KIND_READ,    255, 255, 1, '1,  1023,         1, 8'h80);
    add_row(KIND_READ,    0,   0, 0, '0,    127,          1, 8'h00);
    // glyph wraps from 254,254 into the top-left corner
    add_row(KIND_GLYPH,   254, 254, 1, '1,  0,            0, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    0,            1, 8'h1F);
    add_row(KIND_READ,    0,   0, 0, '0,    2,            1, 8'h1F);
    add_row(KIND_GLYPH,   120, 60, 0, 35'h5A5A5A5A5, 0,   0, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    1016,         0, 8'h00);
    add_row(KIND_GLYPH,   10,  5, 1, 35'h2AAAAAAAA, 0,    0, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    138,          0, 8'h00);
    // empty glyph in dark color lights every cell, clipped at the right edge
    add_row(KIND_GLYPH,   126, 0, 0, '0,    0,            0, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    126,          1, 8'h7F);
    add_row(KIND_PIXEL,   126, 3, 0, '0,    0,            0, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    126,          1, 8'h77);
    add_row(KIND_PIXEL,   0,   0, 0, '0,    0,            0, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    0,            1, 8'h1E);
    add_row(KIND_CLEAR,   0,   0, 0, '0,    0,            0, 8'h00);
    add_row(KIND_READ,    0,   0, 0, '0,    126,          1, 8'h00);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      drive_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].data);
      if ($urandom_range(0, 3) == 0) idle_input($urandom_range(1, 16));
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      w = random_word();
      drive_word(w, 1'b0, 8'h00);
      if (!calm && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 16));
    end
    idle_input(1);

    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d words driven (%0d directed, %0d clears), %0d read bytes compared",
             words_sent, directed_rows.size(), clears_sent, reads_checked);
    $display("output held off for %0d cycles once; %0d mismatches", HOLD_CYCLES, errors);
    if (errors == 0) begin
      $display("[mono_page_framebuffer_engine] OK");
    end else begin
      $display("[mono_page_framebuffer_engine] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mpfe_pkg.sv
rtl/mpfe_ram.sv
rtl/mpfe_ctrl.sv
rtl/mpfe_datapath.sv
rtl/mono_page_framebuffer_engine.sv
rtl/mpfe_checker.sv
test/tb_mono_page_framebuffer_engine.sv
